// ----- hdl/pidat_pkg.sv -----
// Package with the shared constants, register map and fixed-point helpers of the PID autotuner.
package pidat_pkg;

  localparam int GAIN_W  = 31;
  localparam int ANGLE_W = 32;

  // Fixed-point format and the scaling of the working gains.
  localparam int FRAC_BITS  = 16;
  localparam int GAIN_SHIFT = 8;
  localparam int SHL_W      = GAIN_W + 16;  // room for the largest gain shift

  localparam logic [GAIN_W-1:0] MAX31 = {GAIN_W{1'b1}};

  // Item kinds carried on in_tuser.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  // The I gain is tested on every third tuning cycle.
  localparam logic [1:0] I_TEST_PERIOD = 2'd3;

  // Configuration register map, one 32-bit word per register.
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_TARGET    = 3'd0;
  localparam logic [2:0] REG_MAX_OSC   = 3'd1;
  localparam logic [2:0] REG_SETTLE    = 3'd2;
  localparam logic [2:0] REG_INC       = 3'd3;
  localparam logic [2:0] REG_DEC       = 3'd4;
  localparam logic [2:0] REG_MIN_I     = 3'd5;
  localparam logic [2:0] REG_D_FACTOR  = 3'd6;
  localparam logic [2:0] REG_D_FAC_INV = 3'd7;

  localparam logic [GAIN_W-1:0] RST_TARGET    = 31'd655360;
  localparam logic [GAIN_W-1:0] RST_MAX_OSC   = 31'd131072;
  localparam logic [GAIN_W-1:0] RST_SETTLE    = 31'd16384;
  localparam logic [GAIN_W-1:0] RST_INC       = 31'd68813;
  localparam logic [GAIN_W-1:0] RST_DEC       = 31'd62259;
  localparam logic [GAIN_W-1:0] RST_MIN_I     = 31'd65536;
  localparam logic [GAIN_W-1:0] RST_D_FACTOR  = 31'd78643;
  localparam logic [GAIN_W-1:0] RST_D_FAC_INV = 31'd54613;

  // Drops the fraction bits of a full product and saturates to 31 bits.
  function automatic logic [GAIN_W-1:0] fx_sat(input logic [2*GAIN_W-1:0] prod);
    logic [2*GAIN_W-1:0] s;
    s = prod >> FRAC_BITS;
    return (|s[2*GAIN_W-1:GAIN_W]) ? MAX31 : s[GAIN_W-1:0];
  endfunction

  // Scales a gain up into working form, saturating to 31 bits.
  function automatic logic [GAIN_W-1:0] gain_up(input logic [GAIN_W-1:0] g);
    logic [SHL_W-1:0] s;
    s = SHL_W'(g) << GAIN_SHIFT;
    return (|s[SHL_W-1:GAIN_W]) ? MAX31 : s[GAIN_W-1:0];
  endfunction

endpackage

// ----- hdl/pid_step_response_autotuner_top.sv -----
// Top level of the step-response PID autotuner: stream ports, register file and datapath.
//
//  Channel | Direction | Handshake           | Payload
//  in_*    | slave     | in_tvalid/in_tready | in_tuser kind, in_tdata tick/start/stop data
//  out_*   | master    | out_tvalid/tready   | out_tuser error_valid, out_tdata gains + error
//  cfg_*   | APB slave | psel/penable/pready | 8 registers of 31 bits at byte address 4*i
//
// Every input beat produces exactly one output beat. A beat is held in the input
// register, then the tuning update (compares, one pair of 31x31 fixed-point multipliers,
// saturation) runs in a single pass into the state and the output register, and a new
// beat is taken every cycle while out_tready is high. The state written by one beat is in place
// for the beat right behind it. When out_tready is low the output register holds and the
// input register fills, after which in_tready drops. Reset (rst_n, synchronous) clears the
// tuner state and loads the register defaults; pready is always high.
module pid_step_response_autotuner_top
  import pidat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] armed, [32:1] attitude, [63:33] time_slice, [94:64] start_p_gain,
  // [125:95] start_i_gain, [156:126] start_d_gain, [159:157] zero
  input  logic [159:0]          in_tdata,
  // [1:0] kind
  input  logic [1:0]            in_tuser,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] tuned_axis, [32:1] angle_error, [63:33] p_gain, [94:64] i_gain,
  // [125:95] d_gain, [126] save_request, [127] zero
  output logic [127:0]          out_tdata,
  // [0] error_valid
  output logic                  out_tuser,

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // Configuration registers.
  logic [GAIN_W-1:0] target_r, max_osc_r, settle_r, inc_r, dec_r, min_i_r, d_fac_r, d_inv_r;

  // Input register.
  logic                     in_v_r;
  logic [1:0]               in_kind_r;
  logic                     in_armed_r;
  logic signed [ANGLE_W-1:0] in_att_r;
  logic [GAIN_W-1:0]        in_ts_r, in_sp_r, in_si_r, in_sd_r;

  // Tuner state.
  logic                      rising_r, rising_nxt;
  logic                      axis_r, axis_nxt;
  logic                      have_data_r, have_data_nxt;
  logic [1:0]                cycle_phase_r, cycle_phase_nxt;
  logic signed [ANGLE_W-1:0] first_peak_r, first_peak_nxt;
  logic signed [ANGLE_W-1:0] second_peak_r, second_peak_nxt;
  logic signed [ANGLE_W-1:0] target_at_peak_r, target_at_peak_nxt;
  logic [GAIN_W-1:0]         search_time_r, search_time_nxt;
  logic [GAIN_W-1:0]         p_work_r, p_work_nxt;
  logic [GAIN_W-1:0]         i_work_r, i_work_nxt;
  logic [GAIN_W-1:0]         d_work_r, d_work_nxt;

  // Output register.
  logic                      out_v_r;
  logic                      out_evalid_r, out_evalid_nxt;
  logic                      out_axis_r, out_axis_nxt;
  logic signed [ANGLE_W-1:0] out_err_r, out_err_nxt;
  logic [GAIN_W-1:0]         out_p_r, out_p_nxt;
  logic [GAIN_W-1:0]         out_i_r, out_i_nxt;
  logic [GAIN_W-1:0]         out_d_r, out_d_nxt;
  logic                      out_save_r, out_save_nxt;

  logic advance, fire, cfg_wr;
  assign advance   = !out_v_r || out_tready;
  assign fire      = in_v_r && advance;
  assign in_tready = !in_v_r || advance;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  // Decoded kind of the beat in the input register.
  logic is_start, is_stop, is_tick;
  assign is_start = in_armed_r && (in_kind_r == KIND_START);
  assign is_stop  = in_armed_r && (in_kind_r == KIND_STOP);
  assign is_tick  = in_armed_r && !is_start && !is_stop;

  // Response measurement: the angle is mirrored while the target is negative.
  logic signed [ANGLE_W-1:0] tgt, neg_att, cur, sp_min;
  logic signed [ANGLE_W:0]   ct_diff, osc, half_s, max_osc_s;
  logic [ANGLE_W-1:0]        st_sum;
  logic [GAIN_W-1:0]         st_add;
  logic                      ct_small, done, overshoot, osc_big;

  always_comb begin
    tgt     = have_data_r ? $signed({1'b0, target_r}) : '0;
    neg_att = (in_att_r == {1'b1, {(ANGLE_W-1){1'b0}}}) ? $signed({1'b0, MAX31}) : -in_att_r;
    cur     = rising_r ? in_att_r : neg_att;
    st_sum  = {1'b0, search_time_r} + {1'b0, in_ts_r};
    if (second_peak_r != '0) begin
      st_add = st_sum[ANGLE_W-1] ? MAX31 : st_sum[GAIN_W-1:0];
    end else begin
      st_add = search_time_r;
    end
    half_s    = $signed({3'b000, max_osc_r[GAIN_W-1:1]});
    max_osc_s = $signed({2'b00, max_osc_r});
    ct_diff   = $signed({cur[ANGLE_W-1], cur}) - $signed({tgt[ANGLE_W-1], tgt});
    ct_small  = ct_diff < half_s;
    sp_min    = (cur < second_peak_r) ? cur : second_peak_r;
    osc       = $signed({first_peak_r[ANGLE_W-1], first_peak_r})
              - $signed({sp_min[ANGLE_W-1], sp_min});
    done      = (st_add > settle_r) || ((osc > half_s) && (cur > second_peak_r));
    overshoot = first_peak_r > target_at_peak_r;
    osc_big   = osc > max_osc_s;
  end

  // Two multipliers. Unit A is shared by the start D scaling, the final D on stop,
  // the I test and the P update; unit B serves the D update of a finished cycle.
  logic [GAIN_W-1:0]   a_x, a_y, b_y, res_a, res_b, i_floor;
  logic [2*GAIN_W-1:0] prod_a, prod_b;

  always_comb begin
    if (is_start) begin
      a_x = in_sd_r;
      a_y = d_inv_r;
    end else if (is_stop) begin
      a_x = d_work_r;
      a_y = d_fac_r;
    end else if (second_peak_r == '0) begin
      a_x = i_work_r;
      a_y = ct_small ? inc_r : dec_r;
    end else begin
      a_x = p_work_r;
      a_y = overshoot ? dec_r : inc_r;
    end
    b_y = overshoot ? inc_r : dec_r;
  end

  assign prod_a  = a_x * a_y;
  assign prod_b  = d_work_r * b_y;
  assign res_a   = fx_sat(prod_a);
  assign res_b   = fx_sat(prod_b);
  assign i_floor = (res_a < min_i_r) ? min_i_r : res_a;

  // Next state and result for the beat in the input register.
  logic [1:0]              cp_inc;
  logic signed [ANGLE_W+1:0] err_raw;

  always_comb begin
    rising_nxt         = rising_r;
    axis_nxt           = axis_r;
    have_data_nxt      = have_data_r;
    cycle_phase_nxt    = cycle_phase_r;
    first_peak_nxt     = first_peak_r;
    second_peak_nxt    = second_peak_r;
    target_at_peak_nxt = target_at_peak_r;
    search_time_nxt    = search_time_r;
    p_work_nxt         = p_work_r;
    i_work_nxt         = i_work_r;
    d_work_nxt         = d_work_r;
    cp_inc             = cycle_phase_r + 2'd1;

    if (is_start) begin
      p_work_nxt      = gain_up(in_sp_r);
      i_work_nxt      = gain_up(in_si_r);
      d_work_nxt      = gain_up(res_a);
      cycle_phase_nxt = 2'd1;
      first_peak_nxt  = '0;
      second_peak_nxt = '0;
      rising_nxt      = 1'b0;
    end else if (is_tick) begin
      search_time_nxt = st_add;
      if (second_peak_r == '0) begin
        // Still looking for the first peak.
        if (cur > first_peak_r) begin
          first_peak_nxt     = cur;
          target_at_peak_nxt = tgt;
        end else if (first_peak_r > 0) begin
          if (cycle_phase_r == 2'd0) begin
            // I test ends at the first peak.
            i_work_nxt      = ct_small ? res_a : i_floor;
            cycle_phase_nxt = 2'd1;
            rising_nxt      = !rising_r;
            first_peak_nxt  = '0;
            second_peak_nxt = '0;
          end else begin
            second_peak_nxt = cur;
            search_time_nxt = '0;
          end
        end
      end else begin
        // Tracking the trough after the first peak.
        second_peak_nxt = sp_min;
        if (done) begin
          if (overshoot) begin
            p_work_nxt = res_a;
            d_work_nxt = res_b;
          end else if (osc_big) begin
            d_work_nxt = res_b;
          end else begin
            p_work_nxt = res_a;
          end
          rising_nxt      = !rising_r;
          first_peak_nxt  = '0;
          second_peak_nxt = '0;
          cycle_phase_nxt = (cp_inc == I_TEST_PERIOD) ? 2'd0 : cp_inc;
        end
      end
    end else if (is_stop) begin
      axis_nxt = !axis_r;
    end

    if (is_start || is_tick) begin
      have_data_nxt = (target_r != '0);
    end

    // Result fields.
    out_evalid_nxt = is_start || is_tick;
    out_axis_nxt   = axis_r;
    out_save_nxt   = !in_armed_r && (in_kind_r == KIND_START) && have_data_r;
    err_raw = (rising_nxt ? $signed({3'b000, target_r}) : -$signed({3'b000, target_r}))
            - $signed({{2{in_att_r[ANGLE_W-1]}}, in_att_r});
    if (!out_evalid_nxt) begin
      out_err_nxt = '0;
    end else if (err_raw > $signed({3'b000, MAX31})) begin
      out_err_nxt = {1'b0, MAX31};
    end else if (err_raw < -$signed({3'b000, MAX31}) - 1) begin
      out_err_nxt = {1'b1, {(ANGLE_W-1){1'b0}}};
    end else begin
      out_err_nxt = err_raw[ANGLE_W-1:0];
    end
    out_p_nxt = p_work_nxt >> GAIN_SHIFT;
    if (is_stop) begin
      out_i_nxt = i_work_nxt >> GAIN_SHIFT;
      out_d_nxt = res_a >> GAIN_SHIFT;
    end else begin
      out_i_nxt = (cycle_phase_nxt == 2'd0) ? (i_work_nxt >> GAIN_SHIFT) : '0;
      out_d_nxt = d_work_nxt >> GAIN_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= RST_TARGET;
      max_osc_r <= RST_MAX_OSC;
      settle_r  <= RST_SETTLE;
      inc_r     <= RST_INC;
      dec_r     <= RST_DEC;
      min_i_r   <= RST_MIN_I;
      d_fac_r   <= RST_D_FACTOR;
      d_inv_r   <= RST_D_FAC_INV;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_TARGET:    target_r  <= cfg_pwdata[GAIN_W-1:0];
        REG_MAX_OSC:   max_osc_r <= cfg_pwdata[GAIN_W-1:0];
        REG_SETTLE:    settle_r  <= cfg_pwdata[GAIN_W-1:0];
        REG_INC:       inc_r     <= cfg_pwdata[GAIN_W-1:0];
        REG_DEC:       dec_r     <= cfg_pwdata[GAIN_W-1:0];
        REG_MIN_I:     min_i_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_D_FACTOR:  d_fac_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_D_FAC_INV: d_inv_r   <= cfg_pwdata[GAIN_W-1:0];
        default:       target_r  <= target_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_TARGET:    cfg_prdata = {1'b0, target_r};
      REG_MAX_OSC:   cfg_prdata = {1'b0, max_osc_r};
      REG_SETTLE:    cfg_prdata = {1'b0, settle_r};
      REG_INC:       cfg_prdata = {1'b0, inc_r};
      REG_DEC:       cfg_prdata = {1'b0, dec_r};
      REG_MIN_I:     cfg_prdata = {1'b0, min_i_r};
      REG_D_FACTOR:  cfg_prdata = {1'b0, d_fac_r};
      REG_D_FAC_INV: cfg_prdata = {1'b0, d_inv_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r  <= in_tuser;
      in_armed_r <= in_tdata[0];
      in_att_r   <= in_tdata[32:1];
      in_ts_r    <= in_tdata[63:33];
      in_sp_r    <= in_tdata[94:64];
      in_si_r    <= in_tdata[125:95];
      in_sd_r    <= in_tdata[156:126];
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_evalid_r <= out_evalid_nxt;
      out_axis_r   <= out_axis_nxt;
      out_err_r    <= out_err_nxt;
      out_p_r      <= out_p_nxt;
      out_i_r      <= out_i_nxt;
      out_d_r      <= out_d_nxt;
      out_save_r   <= out_save_nxt;
    end
  end

  // Handshake control and tuner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r           <= 1'b0;
      out_v_r          <= 1'b0;
      rising_r         <= 1'b0;
      axis_r           <= 1'b0;
      have_data_r      <= 1'b0;
      cycle_phase_r    <= 2'd1;
      first_peak_r     <= '0;
      second_peak_r    <= '0;
      target_at_peak_r <= '0;
      search_time_r    <= '0;
      p_work_r         <= '0;
      i_work_r         <= '0;
      d_work_r         <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
      if (fire) begin
        rising_r         <= rising_nxt;
        axis_r           <= axis_nxt;
        have_data_r      <= have_data_nxt;
        cycle_phase_r    <= cycle_phase_nxt;
        first_peak_r     <= first_peak_nxt;
        second_peak_r    <= second_peak_nxt;
        target_at_peak_r <= target_at_peak_nxt;
        search_time_r    <= search_time_nxt;
        p_work_r         <= p_work_nxt;
        i_work_r         <= i_work_nxt;
        d_work_r         <= d_work_nxt;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_evalid_r;
  assign out_tdata  = {1'b0, out_save_r, out_d_r, out_i_r, out_p_r, out_err_r, out_axis_r};

  // A trough is only tracked once a positive first peak has been seen.
  a_trough_after_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (second_peak_r != '0) |-> (first_peak_r > 0))
    else $error("trough tracked without a positive first peak");

  // The cycle counter wraps before reaching the I test period.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    cycle_phase_r != I_TEST_PERIOD)
    else $error("cycle phase reached the I test period");

  // An unarmed beat leaves the working gains alone.
  a_unarmed_gains: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !in_armed_r) |=> ($stable(p_work_r) && $stable(i_work_r) && $stable(d_work_r)))
    else $error("working gains changed on an unarmed beat");

  // Without a valid error the error field is zero.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_evalid_r) |-> (out_err_r == '0))
    else $error("angle error driven while not valid");

  // A save request only comes from an unarmed beat.
  a_save_unarmed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_save_r) |-> !out_evalid_r)
    else $error("save request on an armed beat");

endmodule

// ----- tb/sv/autotune_checker.sv -----
// Checker for the PID autotuner: predicts every result beat and compares it with the block's output.
module autotune_checker
  import pidat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [159:0]          in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [127:0]          out_tdata,
  input  logic                  out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  input  logic [31:0]           cfg_prdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [GAIN_W-1:0] gain_t;

  typedef struct packed {
    logic        err_valid;
    logic        axis;
    logic [31:0] angle_err;
    gain_t       p_gain;
    gain_t       i_gain;
    gain_t       d_gain;
    logic        save_req;
  } tuner_beat_t;

  localparam logic [1:0] I_TEST_PHASE = 2'd0;

  gain_t target_reg, maxosc_reg, settle_reg, inc_reg, dec_reg, min_i_reg, dfac_reg, dinv_reg;

  logic       rising, axis_sel, have_data;
  logic [1:0] cycle_ph;
  longint     peak_hi, peak_lo, peak_target;
  gain_t      search_t, p_work, i_work, d_work;

  tuner_beat_t expected_beats[$];
  int          fail_tally = 0;

  assign mismatches = fail_tally;

  function automatic gain_t clip31(logic [63:0] v);
    return (v > 64'(MAX31)) ? MAX31 : v[GAIN_W-1:0];
  endfunction

  function automatic gain_t fix_mul(gain_t a, gain_t b);
    return clip31((64'(a) * 64'(b)) >> FRAC_BITS);
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Follows the response of one step: first the peak, then the trough after it. A trough
  // of exactly zero reads as no trough yet.
  function automatic void judge_response(longint cur, longint tgt);
    longint half_osc, osc;
    half_osc = longint'(maxosc_reg >> 1);
    if (peak_lo == 0) begin
      if (cur > peak_hi) begin
        peak_hi = cur;
        peak_target = tgt;
      end else if (peak_hi > 0) begin
        if (cycle_ph == I_TEST_PHASE) begin
          if (cur - tgt < half_osc) begin
            i_work = fix_mul(i_work, inc_reg);
          end else begin
            i_work = fix_mul(i_work, dec_reg);
            if (i_work < min_i_reg) i_work = min_i_reg;
          end
          cycle_ph = 2'd1;
          rising = !rising;
          peak_hi = 0;
          peak_lo = 0;
        end else begin
          peak_lo = cur;
          search_t = '0;
        end
      end
    end else begin
      if (cur < peak_lo) peak_lo = cur;
      osc = peak_hi - peak_lo;
      if (search_t > settle_reg || (osc > half_osc && cur > peak_lo)) begin
        if (peak_hi > peak_target) begin
          p_work = fix_mul(p_work, dec_reg);
          d_work = fix_mul(d_work, inc_reg);
        end else if (osc > longint'(maxosc_reg)) begin
          d_work = fix_mul(d_work, dec_reg);
        end else begin
          p_work = fix_mul(p_work, inc_reg);
        end
        rising = !rising;
        peak_hi = 0;
        peak_lo = 0;
        cycle_ph = cycle_ph + 2'd1;
        if (cycle_ph == I_TEST_PERIOD) cycle_ph = I_TEST_PHASE;
      end
    end
  endfunction

  function automatic tuner_beat_t tune_step(logic [1:0] kind, logic [159:0] d);
    logic              armed, stop;
    logic signed [31:0] att;
    gain_t             ts, sp, si, sd;
    longint            cur, tgt, set_point;
    tuner_beat_t       r;
    armed = d[0];
    att   = d[32:1];
    ts    = d[63:33];
    sp    = d[94:64];
    si    = d[125:95];
    sd    = d[156:126];
    stop  = 1'b0;
    r.err_valid = 1'b0;
    r.axis      = axis_sel;
    r.angle_err = '0;
    r.save_req  = 1'b0;
    if (!armed) begin
      r.save_req = (kind == KIND_START) && have_data;
    end else if (kind == KIND_STOP) begin
      stop = 1'b1;
    end else begin
      if (kind == KIND_START) begin
        p_work   = clip31(64'(sp) << GAIN_SHIFT);
        i_work   = clip31(64'(si) << GAIN_SHIFT);
        d_work   = clip31(64'(fix_mul(sd, dinv_reg)) << GAIN_SHIFT);
        cycle_ph = 2'd1;
        peak_hi  = 0;
        peak_lo  = 0;
        rising   = 1'b0;
      end else begin
        tgt = have_data ? longint'(target_reg) : 0;
        cur = rising ? longint'(att) : longint'($signed(clip32(-longint'(att))));
        if (peak_lo != 0) search_t = clip31(64'(search_t) + 64'(ts));
        judge_response(cur, tgt);
      end
      have_data   = (target_reg != 0);
      r.err_valid = 1'b1;
      set_point   = rising ? longint'(target_reg) : -longint'(target_reg);
      r.angle_err = clip32(set_point - longint'(att));
    end
    r.p_gain = p_work >> GAIN_SHIFT;
    if (stop) begin
      r.i_gain = i_work >> GAIN_SHIFT;
      r.d_gain = fix_mul(d_work, dfac_reg) >> GAIN_SHIFT;
      axis_sel = !axis_sel;
    end else begin
      r.i_gain = (cycle_ph == I_TEST_PHASE) ? (i_work >> GAIN_SHIFT) : '0;
      r.d_gain = d_work >> GAIN_SHIFT;
    end
    return r;
  endfunction

  task automatic diff_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", field, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    tuner_beat_t want, got;
    logic [31:0] reg_val;
    if (!rst_n) begin
      target_reg  = RST_TARGET;
      maxosc_reg  = RST_MAX_OSC;
      settle_reg  = RST_SETTLE;
      inc_reg     = RST_INC;
      dec_reg     = RST_DEC;
      min_i_reg   = RST_MIN_I;
      dfac_reg    = RST_D_FACTOR;
      dinv_reg    = RST_D_FAC_INV;
      rising      = 1'b0;
      axis_sel    = 1'b0;
      have_data   = 1'b0;
      cycle_ph    = 2'd1;
      peak_hi     = 0;
      peak_lo     = 0;
      peak_target = 0;
      search_t    = '0;
      p_work      = '0;
      i_work      = '0;
      d_work      = '0;
      expected_beats.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[4:2])
            REG_TARGET:    target_reg = cfg_pwdata[GAIN_W-1:0];
            REG_MAX_OSC:   maxosc_reg = cfg_pwdata[GAIN_W-1:0];
            REG_SETTLE:    settle_reg = cfg_pwdata[GAIN_W-1:0];
            REG_INC:       inc_reg    = cfg_pwdata[GAIN_W-1:0];
            REG_DEC:       dec_reg    = cfg_pwdata[GAIN_W-1:0];
            REG_MIN_I:     min_i_reg  = cfg_pwdata[GAIN_W-1:0];
            REG_D_FACTOR:  dfac_reg   = cfg_pwdata[GAIN_W-1:0];
            default:       dinv_reg   = cfg_pwdata[GAIN_W-1:0];
          endcase
        end else begin
          case (cfg_paddr[4:2])
            REG_TARGET:    reg_val = {1'b0, target_reg};
            REG_MAX_OSC:   reg_val = {1'b0, maxosc_reg};
            REG_SETTLE:    reg_val = {1'b0, settle_reg};
            REG_INC:       reg_val = {1'b0, inc_reg};
            REG_DEC:       reg_val = {1'b0, dec_reg};
            REG_MIN_I:     reg_val = {1'b0, min_i_reg};
            REG_D_FACTOR:  reg_val = {1'b0, dfac_reg};
            default:       reg_val = {1'b0, dinv_reg};
          endcase
          diff_field("register readback", reg_val, cfg_prdata);
        end
      end
      // The input side goes first so that a result leaving at the same edge still
      // finds its expectation.
      if (in_tvalid && in_tready) expected_beats.push_back(tune_step(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got.err_valid = out_tuser;
        got.axis      = out_tdata[0];
        got.angle_err = out_tdata[32:1];
        got.p_gain    = out_tdata[63:33];
        got.i_gain    = out_tdata[94:64];
        got.d_gain    = out_tdata[125:95];
        got.save_req  = out_tdata[126];
        if (expected_beats.size() == 0) begin
          $error("result beat arrived with no expectation pending");
          fail_tally++;
        end else begin
          want = expected_beats.pop_front();
          diff_field("error_valid", 32'(want.err_valid), 32'(got.err_valid));
          diff_field("tuned_axis", 32'(want.axis), 32'(got.axis));
          diff_field("angle_error", want.angle_err, got.angle_err);
          diff_field("p_gain", 32'(want.p_gain), 32'(got.p_gain));
          diff_field("i_gain", 32'(want.i_gain), 32'(got.i_gain));
          diff_field("d_gain", 32'(want.d_gain), 32'(got.d_gain));
          diff_field("save_request", 32'(want.save_req), 32'(got.save_req));
        end
      end
    end
    awaiting <= expected_beats.size();
  end

endmodule

// ----- tb/sv/tb_pid_step_response_autotuner_top.sv -----
// Testbench top for the PID autotuner: clock, reset, stimulus, back-pressure and the verdict.
module tb_pid_step_response_autotuner_top
  import pidat_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [GAIN_W-1:0] gain_t;

  // The spare kind code is not named by the block; it behaves as a tuning tick.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Idle mixes applied per phase.
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  // Register programming styles.
  localparam int CFG_KEEP    = 0;
  localparam int CFG_TYPICAL = 1;
  localparam int CFG_ZERO    = 2;
  localparam int CFG_MAX     = 3;
  localparam int CFG_MIXED   = 4;
  localparam int CFG_FULL    = 5;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_BEATS = 205;
  localparam int HOLD_CYCLES = 120;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  // [0] armed, [32:1] attitude, [63:33] time_slice, [94:64] start_p_gain,
  // [125:95] start_i_gain, [156:126] start_d_gain, [159:157] zero
  logic [159:0]          in_tdata    = '0;
  // [1:0] kind
  logic [1:0]            in_tuser    = KIND_TICK;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  // [0] tuned_axis, [32:1] angle_error, [63:33] p_gain, [94:64] i_gain,
  // [125:95] d_gain, [126] save_request, [127] zero
  logic [127:0]          out_tdata;
  // [0] error_valid
  logic                  out_tuser;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int awaiting;

  // Knobs shared by the stimulus and the back-pressure process.
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int hold_asked   = 0;
  int items_sent   = 0;

  // Bookkeeping of the receiver's long hold.
  int holds_taken  = 0;
  int hold_left    = 0;

  // Copies of the registers that shape the step responses we generate.
  gain_t step_mag   = RST_TARGET;
  gain_t osc_limit  = RST_MAX_OSC;
  gain_t settle_lim = RST_SETTLE;

  // Sign that turns a response value into an attitude. Right after a start the tuner
  // looks at the negated attitude, so the first step is driven negative; each burst
  // flips it, and a burst that leaves the tuner in the same half cycle falls back in
  // step after one more burst.
  int step_sign = -1;

  pid_step_response_autotuner_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  autotune_checker tuning_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (fail_count),
    .awaiting    (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side. A hold request from the stimulus makes this process keep out_tready
  // low for a long stretch, counted here, so that the block backs up and drops in_tready
  // while the sender keeps offering beats. Otherwise it stalls at the phase's rate.
  always @(posedge clk) begin
    if (hold_asked != holds_taken) begin
      holds_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [159:0] pack_item(logic armed, logic [31:0] att, gain_t ts,
                                             gain_t sp, gain_t si, gain_t sd);
    return {3'b000, sd, si, sp, ts, att, armed};
  endfunction

  // Mostly modest gains so that the scaling stays visible, sometimes the full range.
  function automatic gain_t rand_gain();
    return ($urandom_range(9) < 7) ? gain_t'($urandom_range(1, 5000)) : gain_t'($urandom);
  endfunction

  function automatic logic [31:0] to_angle(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Offers one beat and returns at the edge that accepts it. in_tvalid stays high so a
  // following beat can go out back to back; random gaps lower it first.
  task automatic send_item(input logic [1:0] kind, input logic [159:0] data);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic noise_item();
    logic [159:0] data;
    data = {$urandom, $urandom, $urandom, $urandom, $urandom};
    data[159:157] = '0;
    send_item(2'($urandom), data);
  endtask

  // One tick of a step response. The time slice is usually a fraction of the settling
  // time, so some trough searches time out and others end on the rebound.
  task automatic burst_tick(input longint cur);
    gain_t ts;
    ts = ($urandom_range(9) == 0) ? gain_t'($urandom)
                                  : gain_t'($urandom_range(0, settle_lim / 4 + 1));
    send_item(KIND_TICK, pack_item($urandom_range(99) < 97, to_angle(step_sign * cur), ts,
                                   gain_t'($urandom), gain_t'($urandom), gain_t'($urandom)));
  endtask

  // A rise to a peak around the target (over or under it), a fall to a trough whose depth
  // is set against the allowed oscillation, and a partial rebound.
  task automatic step_burst();
    longint mag, peak, trough;
    int n_up, n_down, n_back;
    mag    = (step_mag < 1024) ? 1024 : longint'(step_mag);
    peak   = mag * longint'($urandom_range(40, 160)) / 100;
    trough = peak - longint'(osc_limit) * longint'($urandom_range(0, 300)) / 100
                  - longint'($urandom_range(0, 3));
    n_up   = $urandom_range(2, 6);
    n_down = $urandom_range(1, 5);
    n_back = $urandom_range(0, 4);
    for (int k = 1; k <= n_up; k++) burst_tick(peak * k / n_up);
    for (int k = 1; k <= n_down; k++) burst_tick(peak + (trough - peak) * k / n_down);
    for (int k = 1; k <= n_back; k++) burst_tick(trough + (peak - trough) * k / (2 * n_back));
    step_sign = -step_sign;
  endtask

  // Start, a run of step responses, and usually a stop. Now and then an unarmed start
  // comes first, which asks for the gains to be saved once tuning data exists.
  task automatic tuning_session();
    int n_bursts;
    n_bursts = $urandom_range(2, 8);
    if ($urandom_range(9) == 0)
      send_item(KIND_START, pack_item(1'b0, $urandom, gain_t'($urandom), rand_gain(),
                                      rand_gain(), rand_gain()));
    send_item(KIND_START, pack_item(1'b1, $urandom, gain_t'($urandom), rand_gain(),
                                    rand_gain(), rand_gain()));
    step_sign = -1;
    repeat (n_bursts) step_burst();
    if ($urandom_range(9) != 0)
      send_item(KIND_STOP, pack_item(1'b1, $urandom, gain_t'($urandom), gain_t'($urandom),
                                     gain_t'($urandom), gain_t'($urandom)));
  endtask

  // One APB transfer: setup cycle, access cycle, then a cycle with psel low so that the
  // next transfer never touches the same signals in the same time step.
  task automatic apb_access(input logic write, input int idx, input logic [31:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= CFG_ADDR_W'(idx * 4);
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all eight registers in the given style and reads them back. The top bit of a
  // write is not part of any register, so full-range writes also check that it is dropped.
  task automatic program_registers(input int style);
    logic [31:0] typical [8];
    logic [31:0] value;
    typical[REG_TARGET]    = $urandom_range(1 << 16, 40 << 16);
    typical[REG_MAX_OSC]   = $urandom_range(1 << 14, 4 << 16);
    typical[REG_SETTLE]    = $urandom_range(1 << 12, 1 << 16);
    typical[REG_INC]       = $urandom_range(65536, 90000);
    typical[REG_DEC]       = $urandom_range(40000, 65536);
    typical[REG_MIN_I]     = $urandom_range(0, 1 << 18);
    typical[REG_D_FACTOR]  = $urandom_range(50000, 100000);
    typical[REG_D_FAC_INV] = $urandom_range(40000, 70000);
    for (int r = 0; r < 8; r++) begin
      case (style)
        CFG_ZERO:  value = '0;
        CFG_MAX:   value = 32'hffff_ffff;
        CFG_FULL:  value = $urandom;
        CFG_MIXED: begin
          case ($urandom_range(2))
            0:       value = '0;
            1:       value = 32'hffff_ffff;
            default: value = typical[r];
          endcase
        end
        default:   value = typical[r];
      endcase
      apb_access(1'b1, r, value);
      if (r == REG_TARGET) step_mag = value[GAIN_W-1:0];
      if (r == REG_MAX_OSC) osc_limit = value[GAIN_W-1:0];
      if (r == REG_SETTLE) settle_lim = value[GAIN_W-1:0];
    end
    for (int r = 0; r < 8; r++) apb_access(1'b0, r, '0);
  endtask

  // Stops offering beats, waits until every expected result has come out and then lets
  // the two-stage pipe run on so that it is sure to be empty.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int phase_style [NUM_PHASES];
    int phase_end;
    phase_style = '{CFG_KEEP, CFG_TYPICAL, CFG_ZERO, CFG_MAX,
                    CFG_TYPICAL, CFG_MIXED, CFG_FULL, CFG_TYPICAL};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, register defaults, no idling.
    // Unarmed start before any tuning data: no save request.
    send_item(KIND_START, pack_item(1'b0, 32'd0, 31'd0, 31'd0, 31'd0, 31'd0));
    // Largest start gains saturate when shifted into working form.
    send_item(KIND_START, pack_item(1'b1, 32'd0, 31'd0, MAX31, MAX31, MAX31));
    // Most negative attitude: its negation saturates.
    send_item(KIND_TICK, pack_item(1'b1, 32'h8000_0000, 31'd100, '0, '0, '0));
    // Most positive attitude with the longest time slice.
    send_item(KIND_TICK, pack_item(1'b1, 32'h7fff_ffff, MAX31, '0, '0, '0));
    // The spare kind acts as a tick.
    send_item(KIND_SPARE, pack_item(1'b1, 32'd0, 31'd100, '0, '0, '0));
    // Unarmed tick and unarmed stop change nothing; the axis does not flip.
    send_item(KIND_TICK, pack_item(1'b0, 32'h1234_5678, MAX31, MAX31, MAX31, MAX31));
    send_item(KIND_STOP, pack_item(1'b0, 32'd0, '0, '0, '0, '0));
    // Armed stop reports the final gains and flips the axis.
    send_item(KIND_STOP, pack_item(1'b1, 32'd0, '0, '0, '0, '0));
    // Unarmed start with tuning data present asks for a save.
    send_item(KIND_START, pack_item(1'b0, 32'd0, '0, '0, '0, '0));
    send_item(KIND_START, pack_item(1'b1, 32'd0, '0, 31'd1000, 31'd2000, 31'd3000));
    // Falling half cycle: a peak, then a trough of exactly zero that does not count,
    // then a real trough and a rebound that ends the cycle on oscillation (D lowered).
    send_item(KIND_TICK, pack_item(1'b1, -32'sd500000, 31'd100, '0, '0, '0));
    send_item(KIND_TICK, pack_item(1'b1, 32'd0, 31'd100, '0, '0, '0));
    send_item(KIND_TICK, pack_item(1'b1, -32'sd400000, 31'd100, '0, '0, '0));
    send_item(KIND_TICK, pack_item(1'b1, -32'sd100000, 31'd100, '0, '0, '0));
    send_item(KIND_TICK, pack_item(1'b1, -32'sd300000, 31'd100, '0, '0, '0));
    // Rising half cycle with overshoot past the target: P down, D up.
    send_item(KIND_TICK, pack_item(1'b1, 32'd800000, 31'd100, '0, '0, '0));
    send_item(KIND_TICK, pack_item(1'b1, 32'd700000, 31'd100, '0, '0, '0));
    send_item(KIND_TICK, pack_item(1'b1, 32'd600000, 31'd100, '0, '0, '0));
    send_item(KIND_TICK, pack_item(1'b1, 32'd650000, 31'd100, '0, '0, '0));
    // This half cycle is the I test: it ends on the first drop after the peak.
    send_item(KIND_TICK, pack_item(1'b1, -32'sd700000, 31'd100, '0, '0, '0));
    send_item(KIND_TICK, pack_item(1'b1, -32'sd600000, 31'd100, '0, '0, '0));
    send_item(KIND_STOP, pack_item(1'b1, 32'd0, '0, '0, '0, '0));

    // Random part. Each phase but the first programs the registers while the block is idle,
    // then runs mostly well-formed tuning sessions with some raw noise in between.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_block();
      if (phase_style[p] != CFG_KEEP) program_registers(phase_style[p]);
      case (p % 4)
        IDLE_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
        IDLE_SENDER:   begin send_gap_pct = 45; stall_pct = 0;  end
        IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 45; end
        default:       begin send_gap_pct = 20; stall_pct = 20; end
      endcase
      // In the phases without idling the receiver also holds off for a long stretch.
      if (p % 4 == IDLE_NONE) hold_asked++;
      phase_end = items_sent + PHASE_BEATS;
      while (items_sent < phase_end) begin
        if ($urandom_range(3) != 0) tuning_session();
        else repeat ($urandom_range(1, 5)) noise_item();
      end
    end

    drain_block();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a block that stops answering.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
